// ===== hw/rtl/spqs_pkg.sv =====
// Shared types, constants and the coil phase table for the stepper plan queue sequencer.
package spqs_pkg;

    // Number of plan slots in the queue.
    localparam int PLAN_DEPTH = 16;
    localparam int PTR_W      = (PLAN_DEPTH > 1) ? $clog2(PLAN_DEPTH) : 1;
    localparam int CNT_W      = $clog2(PLAN_DEPTH + 1);

    localparam int COUNT_W = 16;
    localparam int DIR_W   = 8;
    localparam int COIL_W  = 4;
    localparam int PHASE_W = 2;

    // Item kinds carried on the mode field.
    localparam logic MODE_TICK    = 1'b0;
    localparam logic MODE_ENQUEUE = 1'b1;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [DIR_W-1:0]   dir;
        logic               release_flag;
    } plan_t;

    localparam int PLAN_W = $bits(plan_t);

    // Full-step drive pattern for each of the four phases.
    function automatic logic [COIL_W-1:0] coil_pattern(input logic [PHASE_W-1:0] phase);
        logic [COIL_W-1:0] pattern;
        begin
            case (phase)
                2'd0:    pattern = 4'h9;
                2'd1:    pattern = 4'h3;
                2'd2:    pattern = 4'h6;
                2'd3:    pattern = 4'hC;
                default: pattern = 4'h0;
            endcase
            return pattern;
        end
    endfunction

endpackage

// ===== hw/rtl/spqs_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module spqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // A read of the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/stepper_plan_queue_sequencer_core.sv =====
// Top level of the stepper plan queue sequencer: plan queue, step logic and result register.
//
// The block drives the four coil inputs of a two-phase stepper in full steps from a queue of
// step plans. Each request on the input channel is either an enqueue, which pushes a plan of
// step count, signed direction and release flag into the queue, or a tick, which advances the
// current plan by one step and loads the next plan from the queue once the current one is done.
// Every request yields exactly one result on the output channel: the coil levels, whether an
// enqueue was stored, how many plans are waiting and whether a plan is still moving.
//
// A request is taken on any clock edge at which in_valid is high and in_stall is low; its
// result appears in the output register on the next cycle, and the block sustains one request
// per cycle while the receiver does not stall. The queue lives in a RAM with a registered
// read; the read address always follows the next head pointer, so the oldest plan is already
// present at the RAM output when a tick wants it, and a plan written into an empty queue is
// forwarded around the RAM in the cycle where its write and read would collide.
//
// After reset the queue is empty, no plan is current and all coils are off. When the receiver
// stalls, the result register holds its contents, and in_stall rises only while that register
// is full and stalled; otherwise a new request is taken while the previous result is delivered.
module stepper_plan_queue_sequencer_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        mode,
    input  logic [15:0]                 step_count,
    input  logic signed [7:0]           direction,
    input  logic                        release_at_end,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [3:0]                  coil_drive,
    output logic                        accepted,
    output logic [spqs_pkg::CNT_W-1:0]  plans_waiting,
    output logic                        moving
);

    import spqs_pkg::*;

    // Architectural state of the sequencer.
    logic [PHASE_W-1:0] phase_reg,      phase_next;
    logic [COUNT_W-1:0] steps_left_reg, steps_left_next;
    logic [DIR_W-1:0]   cur_dir_reg,    cur_dir_next;
    logic               cur_rel_reg,    cur_rel_next;
    logic [COIL_W-1:0]  coils_reg,      coils_next;
    logic [PTR_W-1:0]   rd_ptr_reg,     rd_ptr_next;
    logic [PTR_W-1:0]   wr_ptr_reg,     wr_ptr_next;
    logic [CNT_W-1:0]   fill_reg,       fill_next;

    // Forwarding path around the RAM for a write that hits the head slot.
    logic               bypass_reg,     bypass_next;
    plan_t              bypass_data_reg;

    // Result register.
    logic               out_valid_reg,  out_valid_next;
    logic [COIL_W-1:0]  res_coils_reg;
    logic               res_accepted_reg;
    logic [CNT_W-1:0]   res_fill_reg;
    logic               res_moving_reg;

    logic               in_accept;
    logic               ram_we;
    plan_t              wr_plan;
    plan_t              ram_rdata;
    plan_t              head_plan;
    logic               enq_ok;
    logic [COUNT_W-1:0] steps_loaded;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        begin
            return (p == PTR_W'(PLAN_DEPTH - 1)) ? '0 : p + PTR_W'(1);
        end
    endfunction

    // The input side waits only while a finished result is still held back by the receiver.
    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    assign wr_plan.count        = step_count;
    assign wr_plan.dir          = direction;
    assign wr_plan.release_flag = release_at_end;

    // The oldest waiting plan, either from the RAM or from the forwarding register.
    assign head_plan = bypass_reg ? bypass_data_reg : ram_rdata;

    assign enq_ok = (fill_reg != CNT_W'(PLAN_DEPTH));
    assign ram_we = in_accept && (mode == MODE_ENQUEUE) && enq_ok;

    // Read-modify-write of the sequencer state for the request taken this cycle.
    always_comb
    begin
        phase_next      = phase_reg;
        steps_left_next = steps_left_reg;
        cur_dir_next    = cur_dir_reg;
        cur_rel_next    = cur_rel_reg;
        coils_next      = coils_reg;
        rd_ptr_next     = rd_ptr_reg;
        wr_ptr_next     = wr_ptr_reg;
        fill_next       = fill_reg;
        steps_loaded    = steps_left_reg;

        if (in_accept)
        begin
            case (mode)
                MODE_ENQUEUE:
                begin
                    if (enq_ok)
                    begin
                        wr_ptr_next = next_slot(wr_ptr_reg);
                        fill_next   = fill_reg + CNT_W'(1);
                    end
                end
                MODE_TICK:
                begin
                    // A finished plan releases the coils if its release flag is set and hands over to the next plan.
                    if (steps_left_reg == '0)
                    begin
                        if (cur_rel_reg)
                        begin
                            coils_next = '0;
                        end
                        if (fill_reg != '0)
                        begin
                            steps_loaded = head_plan.count;
                            cur_dir_next = head_plan.dir;
                            cur_rel_next = head_plan.release_flag;
                            rd_ptr_next  = next_slot(rd_ptr_reg);
                            fill_next    = fill_reg - CNT_W'(1);
                        end
                    end
                    steps_left_next = steps_loaded;
                    if (steps_loaded != '0)
                    begin
                        if (cur_dir_next != '0)
                        begin
                            coils_next = coil_pattern(phase_reg);
                            if (cur_dir_next[DIR_W-1])
                            begin
                                phase_next = phase_reg - PHASE_W'(1);
                            end
                            else
                            begin
                                phase_next = phase_reg + PHASE_W'(1);
                            end
                        end
                        steps_left_next = steps_loaded - COUNT_W'(1);
                    end
                end
                default:
                begin
                    steps_left_next = steps_left_reg;
                end
            endcase
        end
    end

    // A write into the slot that is read this cycle would return stale data.
    assign bypass_next = ram_we && (wr_ptr_reg == rd_ptr_next);

    assign out_valid_next = in_accept || (out_valid_reg && out_stall);

    spqs_ram #(
        .WIDTH (PLAN_W),
        .DEPTH (PLAN_DEPTH)
    ) u_plan_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_ptr_reg),
        .wdata (wr_plan),
        .raddr (rd_ptr_next),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= '0;
            steps_left_reg <= '0;
            cur_dir_reg    <= '0;
            cur_rel_reg    <= 1'b0;
            coils_reg      <= '0;
            rd_ptr_reg     <= '0;
            wr_ptr_reg     <= '0;
            fill_reg       <= '0;
            bypass_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            steps_left_reg <= steps_left_next;
            cur_dir_reg    <= cur_dir_next;
            cur_rel_reg    <= cur_rel_next;
            coils_reg      <= coils_next;
            rd_ptr_reg     <= rd_ptr_next;
            wr_ptr_reg     <= wr_ptr_next;
            fill_reg       <= fill_next;
            bypass_reg     <= bypass_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        bypass_data_reg <= wr_plan;
        if (in_accept)
        begin
            res_coils_reg    <= coils_next;
            res_accepted_reg <= ram_we;
            res_fill_reg     <= fill_next;
            res_moving_reg   <= (steps_left_next != '0);
        end
    end

    assign out_valid     = out_valid_reg;
    assign coil_drive    = res_coils_reg;
    assign accepted      = res_accepted_reg;
    assign plans_waiting = res_fill_reg;
    assign moving        = res_moving_reg;

endmodule

// ===== hw/rtl/spqs_checker.sv =====
// Port-level checks for the stepper plan queue sequencer and their binding to the top level.
module spqs_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        mode,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic                        accepted,
    input logic [spqs_pkg::CNT_W-1:0]  plans_waiting
);

    import spqs_pkg::*;

    // A held result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result withdrawn while stalled");

    // Every request taken shows a result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("no result after a request was taken");

    // A tick never reports a stored plan.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (mode == MODE_TICK) |=> !accepted)
        else $error("tick reported as stored");

    // A stored plan leaves at least one plan waiting, and the queue never exceeds its depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!accepted || plans_waiting != '0)
                      && (plans_waiting <= CNT_W'(PLAN_DEPTH)))
        else $error("queue fill level inconsistent");

endmodule

bind stepper_plan_queue_sequencer_core spqs_checker u_spqs_checker (.*);

// ===== tb/sv/stepper_plan_queue_sequencer_core_test.sv =====
// Self-checking testbench for the stepper plan queue sequencer core.
`timescale 1ns / 1ps

module stepper_plan_queue_sequencer_core_test;

    import spqs_pkg::*;

    // Cycles without any request or result being taken before the run is abandoned.
    localparam int STALL_LIMIT = 2000;

    // One request as queued for the driver, with the idling drawn for it.
    typedef struct {
        logic              mode;
        logic [15:0]       count;
        logic signed [7:0] dir;
        logic              release_end;
        int                idle;        // sender gap before this request
        int                hold;        // receiver stall before taking its result
        bit                drain_first; // wait until every result is back before sending
    } request_t;

    // Expected contents of one result.
    typedef struct {
        logic [3:0]       coils;
        logic             stored;
        logic [CNT_W-1:0] waiting;
        logic             busy;
        int               hold;
    } drive_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic                 mode;
    logic [15:0]          step_count;
    logic signed [7:0]    direction;
    logic                 release_at_end;
    logic                 out_valid;
    logic                 out_stall;
    logic [3:0]           coil_drive;
    logic                 accepted;
    logic [CNT_W-1:0]     plans_waiting;
    logic                 moving;

    request_t   request_queue[$];
    drive_t     drive_expected[$];
    int         req_hold;
    int         gap_left;
    int         hold_left;
    int         requests_sent;
    int         requests_total;
    int         results_pending;
    int         quiet_cycles;
    int         errors;
    bit         calm;

    // Own copy of the sequencer state for prediction.
    logic [1:0]        phase_now;
    logic [15:0]       steps_remaining;
    logic [7:0]        plan_dir;
    logic              plan_release;
    logic [3:0]        coils_now;
    plan_t             plan_slots [PLAN_DEPTH];
    int                head_slot;
    int                tail_slot;
    int                plans_held;

    logic [3:0] step_pattern [4] = '{4'h9, 4'h3, 4'h6, 4'hC};

    stepper_plan_queue_sequencer_core DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .step_count     (step_count),
        .direction      (direction),
        .release_at_end (release_at_end),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .coil_drive     (coil_drive),
        .accepted       (accepted),
        .plans_waiting  (plans_waiting),
        .moving         (moving)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Works out the coil levels and queue status that one request leaves behind,
    // advancing the predicted state as it goes.
    function automatic drive_t predict_drive(input logic m, input logic [15:0] cnt,
                                             input logic [7:0] dir, input logic rel);
        drive_t r;
        r.stored = 1'b0;
        if (m == MODE_ENQUEUE)
        begin
            // A full queue drops the plan and leaves everything else alone.
            if (plans_held < PLAN_DEPTH)
            begin
                plan_slots[tail_slot].count        = cnt;
                plan_slots[tail_slot].dir          = dir;
                plan_slots[tail_slot].release_flag = rel;
                tail_slot  = (tail_slot == PLAN_DEPTH - 1) ? 0 : tail_slot + 1;
                plans_held = plans_held + 1;
                r.stored   = 1'b1;
            end
        end
        else
        begin
            // A finished plan releases the coils if asked, then the next plan is loaded.
            if (steps_remaining == 16'd0)
            begin
                if (plan_release)
                    coils_now = 4'h0;
                if (plans_held > 0)
                begin
                    steps_remaining = plan_slots[head_slot].count;
                    plan_dir        = plan_slots[head_slot].dir;
                    plan_release    = plan_slots[head_slot].release_flag;
                    head_slot  = (head_slot == PLAN_DEPTH - 1) ? 0 : head_slot + 1;
                    plans_held = plans_held - 1;
                end
            end
            // A zero direction is a pure delay: the count drops but the coils stay.
            if (steps_remaining != 16'd0)
            begin
                if (plan_dir != 8'd0)
                begin
                    coils_now = step_pattern[phase_now];
                    phase_now = plan_dir[7] ? phase_now - 2'd1 : phase_now + 2'd1;
                end
                steps_remaining = steps_remaining - 16'd1;
            end
        end
        r.coils   = coils_now;
        r.waiting = plans_held[CNT_W-1:0];
        r.busy    = (steps_remaining != 16'd0);
        r.hold    = 0;
        return r;
    endfunction

    // Queues one request; idling is drawn here unless a calm stretch is being built.
    task automatic queue_request(input logic m, input logic [15:0] cnt,
                                 input logic [7:0] dir, input logic rel, input bit drain);
        request_t q;
        q.mode        = m;
        q.count       = cnt;
        q.dir         = dir;
        q.release_end = rel;
        q.idle        = calm ? 0 : $urandom_range(0, 10);
        q.hold        = calm ? 0 : $urandom_range(0, 10);
        q.drain_first = drain;
        request_queue.push_back(q);
    endtask

    task automatic queue_tick(input int n);
        int k;
        for (k = 0; k < n; k++)
            queue_request(MODE_TICK, 16'($urandom), 8'($urandom), 1'($urandom), 1'b0);
    endtask

    // Driver: presents requests from the queue, holding each one until it is taken.
    always @(posedge clk or negedge rst_n)
    begin
        int       g;
        bit       fire;
        request_t q;
        if (!rst_n)
        begin
            in_valid       <= 1'b0;
            mode           <= MODE_TICK;
            step_count     <= 16'd0;
            direction      <= 8'sd0;
            release_at_end <= 1'b0;
            req_hold       <= 0;
            gap_left       <= -1;
            requests_sent  <= 0;
        end
        else
        begin
            fire = in_valid && !in_stall;
            if (fire)
                requests_sent <= requests_sent + 1;
            if (!in_valid || fire)
            begin
                // The slot is free: count down the gap drawn for the next request first.
                g = gap_left;
                if (g < 0 && request_queue.size() > 0)
                    g = request_queue[0].idle;
                if (g > 0)
                begin
                    gap_left <= g - 1;
                    in_valid <= 1'b0;
                end
                else if (request_queue.size() > 0 &&
                         !(request_queue[0].drain_first && (fire || results_pending != 0)))
                begin
                    q = request_queue.pop_front();
                    mode           <= q.mode;
                    step_count     <= q.count;
                    direction      <= q.dir;
                    release_at_end <= q.release_end;
                    req_hold       <= q.hold;
                    in_valid       <= 1'b1;
                    gap_left       <= -1;
                end
                else
                begin
                    in_valid <= 1'b0;
                    gap_left <= g;
                end
            end
        end
    end

    // Monitor: predicts on every request taken, checks every result taken and
    // drives the receiver's stall.
    always @(posedge clk or negedge rst_n)
    begin
        drive_t e;
        if (!rst_n)
        begin
            out_stall       <= 1'b0;
            results_pending <= 0;
            hold_left = -1;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (drive_expected.size() == 0)
                begin
                    $error("result taken with no request outstanding");
                    errors++;
                end
                else
                begin
                    e = drive_expected.pop_front();
                    if (coil_drive !== e.coils)
                    begin
                        $error("coil_drive: expected %h, got %h", e.coils, coil_drive);
                        errors++;
                    end
                    if (accepted !== e.stored)
                    begin
                        $error("accepted: expected %b, got %b", e.stored, accepted);
                        errors++;
                    end
                    if (plans_waiting !== e.waiting)
                    begin
                        $error("plans_waiting: expected %0d, got %0d", e.waiting, plans_waiting);
                        errors++;
                    end
                    if (moving !== e.busy)
                    begin
                        $error("moving: expected %b, got %b", e.busy, moving);
                        errors++;
                    end
                end
                hold_left = -1;
            end
            if (in_valid && !in_stall)
            begin
                e = predict_drive(mode, step_count, direction, release_at_end);
                e.hold = req_hold;
                drive_expected.push_back(e);
            end
            // Each result gets the stall that was drawn for its request.
            if (hold_left < 0 && drive_expected.size() > 0)
                hold_left = drive_expected[0].hold;
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left = hold_left - 1;
            end
            else
                out_stall <= 1'b0;
            results_pending <= drive_expected.size();
        end
    end

    // Watchdog: a run that stops moving for too long is a failure.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL stepper_plan_queue_sequencer_core");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int  k;
        int  s;
        int  enq_pct;
        logic [15:0] cnt;
        logic [7:0]  dir;

        errors          = 0;
        phase_now       = 2'd0;
        steps_remaining = 16'd0;
        plan_dir        = 8'd0;
        plan_release    = 1'b0;
        coils_now       = 4'h0;
        head_slot       = 0;
        tail_slot       = 0;
        plans_held      = 0;
        calm            = 1'b0;

        // Directed part. A tick straight out of reset finds nothing to do.
        queue_tick(1);
        // A short forward plan, stepped out and then followed by an idle tick with no plan waiting.
        queue_request(MODE_ENQUEUE, 16'd3, 8'd1, 1'b0, 1'b0);
        queue_tick(4);
        // A zero-count plan finishes as it loads; its release acts one tick later,
        // and an idle tick after that clears the already dark coils again.
        queue_request(MODE_ENQUEUE, 16'd0, 8'd5, 1'b1, 1'b0);
        queue_tick(3);
        // Backward, delay only and both direction extremes.
        queue_request(MODE_ENQUEUE, 16'd2, 8'hFF, 1'b1, 1'b0);
        queue_request(MODE_ENQUEUE, 16'd1, 8'h00, 1'b0, 1'b0);
        queue_request(MODE_ENQUEUE, 16'd2, 8'h7F, 1'b0, 1'b0);
        queue_request(MODE_ENQUEUE, 16'd1, 8'h80, 1'b1, 1'b0);
        queue_tick(8);
        // Fill the queue once everything has settled, then knock on the full queue
        // with the largest count, which must be turned away.
        for (k = 0; k < PLAN_DEPTH; k++)
            queue_request(MODE_ENQUEUE, 16'(k % 2), 8'(k * 37 - 90), 1'(k), k == 0);
        queue_request(MODE_ENQUEUE, 16'hFFFF, 8'h80, 1'b1, 1'b0);
        queue_request(MODE_ENQUEUE, 16'h8000, 8'h7F, 1'b0, 1'b0);
        queue_tick(PLAN_DEPTH + 3);

        // Random part: stretches that favour enqueues and fill the queue alternate
        // with stretches that favour ticks and drain it; every fourth is calm.
        for (s = 0; s < 12; s++)
        begin
            enq_pct = (s % 2 == 0) ? 60 : 15;
            calm    = (s % 4 == 3);
            for (k = 0; k < 50; k++)
            begin
                if ($urandom_range(0, 99) < enq_pct)
                begin
                    cnt = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 5))
                                                     : 16'($urandom_range(6, 40));
                    dir = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
                    queue_request(MODE_ENQUEUE, cnt, dir, 1'($urandom), s == 6 && k == 0);
                end
                else
                    queue_tick(1);
            end
        end
        calm = 1'b0;
        requests_total = request_queue.size();

        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every request to be taken and every result to come back.
        while (requests_sent != requests_total || results_pending != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);

        if (errors == 0 && drive_expected.size() == 0)
            $display("PASS stepper_plan_queue_sequencer_core");
        else
            $display("FAIL stepper_plan_queue_sequencer_core");
        $finish;
    end

endmodule
